// ----- rtl/mipu_pkg.sv -----
package mipu_pkg;

    typedef enum logic [1:0] {
        KIND_PALETTE = 2'd0,
        KIND_MASK    = 2'd1,
        KIND_PIXEL   = 2'd2,
        KIND_UNUSED  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CFG_DEPTH_CODE      = 3'd0,
        CFG_IMAGE_WIDTH     = 3'd1,
        CFG_IMAGE_HEIGHT    = 3'd2,
        CFG_PIXEL_ROW_BYTES = 3'd3,
        CFG_MASK_ROW_BYTES  = 3'd4
    } cfg_index_t;

    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 8;
    localparam int X_W             = 10;  // up to 128 bytes of 8 pixels
    localparam int ROW_W           = 7;
    localparam int MASK_CALC_W     = 12;  // row * mask_row_bytes + x / 8
    localparam int COLOR_W         = 24;
    localparam int PALETTE_DEPTH   = 256;
    localparam int ROW_BYTES_LIMIT = 128;

    typedef struct packed {
        logic [1:0] depth_code;
        logic [6:0] image_width;
        logic [6:0] image_height;
        logic [7:0] pixel_row_bytes;
        logic [4:0] mask_row_bytes;
    } cfg_t;

    typedef struct packed {
        logic [X_W-1:0]   x;
        logic [ROW_W-1:0] row;
        logic [7:0]       cidx;
        logic             last;
    } pix_req_t;

endpackage

// ----- rtl/mipu_ram.sv -----
module mipu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns old data on a same-cycle write to the same address
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/mipu_unpack.sv -----
module mipu_unpack #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mipu_pkg::cfg_t      cfg,
    input  logic                start,
    input  logic [7:0]          data_byte,
    input  logic                issue,
    output logic                can_take,
    output logic                req_valid,
    output mipu_pkg::pix_req_t  req
);
    import mipu_pkg::*;

    logic                 busy_reg, busy_next;
    logic [7:0]           byte_reg, byte_next;
    logic [X_W-1:0]       x_reg, x_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [3:0]           left_reg, left_next;
    logic [6:0]           rbc_reg, rbc_next;
    logic [ROW_W-1:0]     rcnt_reg, rcnt_next;

    logic [3:0]           per_byte;
    logic [X_W-1:0]       x0;
    logic [X_W-1:0]       diff;
    logic [3:0]           count;
    logic [6:0]           eff_w;
    logic [6:0]           eff_h;
    logic [7:0]           eff_rb;
    logic [7:0]           byte_shifted;
    logic [7:0]           cidx;

    always_comb begin
        unique case (cfg.depth_code)
            2'd0: begin
                per_byte     = 4'd8;
                x0           = {rbc_reg, 3'b000};
                cidx         = {7'd0, byte_reg[7]};
                byte_shifted = {byte_reg[6:0], 1'b0};
            end
            2'd1: begin
                per_byte     = 4'd4;
                x0           = {1'b0, rbc_reg, 2'b00};
                cidx         = {6'd0, byte_reg[7:6]};
                byte_shifted = {byte_reg[5:0], 2'b00};
            end
            2'd2: begin
                per_byte     = 4'd2;
                x0           = {2'b00, rbc_reg, 1'b0};
                cidx         = {4'd0, byte_reg[7:4]};
                byte_shifted = {byte_reg[3:0], 4'h0};
            end
            default: begin
                per_byte     = 4'd1;
                x0           = {3'b000, rbc_reg};
                cidx         = byte_reg;
                byte_shifted = 8'd0;
            end
        endcase
    end

    assign eff_w = 7'((32'(cfg.image_width) > MAX_WIDTH) ? MAX_WIDTH : 32'(cfg.image_width));
    assign eff_h = (cfg.image_height == 7'd0) ? 7'd1 :
                   7'((32'(cfg.image_height) > MAX_HEIGHT) ? MAX_HEIGHT
                                                           : 32'(cfg.image_height));
    assign eff_rb = (cfg.pixel_row_bytes == 8'd0) ? 8'd1 :
                    ((32'(cfg.pixel_row_bytes) > ROW_BYTES_LIMIT) ? 8'(ROW_BYTES_LIMIT)
                                                                  : cfg.pixel_row_bytes);

    // pixels of this byte that fall inside the image width
    assign diff = X_W'(eff_w) - x0;
    always_comb begin
        if (x0 >= X_W'(eff_w)) begin
            count = 4'd0;
        end else if (diff < X_W'(per_byte)) begin
            count = diff[3:0];
        end else begin
            count = per_byte;
        end
    end

    always_comb begin
        rbc_next  = rbc_reg;
        rcnt_next = rcnt_reg;
        if (start) begin
            if (8'(rbc_reg) + 8'd1 >= eff_rb) begin
                rbc_next = 7'd0;
                if (rcnt_reg + 7'd1 >= eff_h) begin
                    rcnt_next = 7'd0;
                end else begin
                    rcnt_next = rcnt_reg + 7'd1;
                end
            end else begin
                rbc_next = rbc_reg + 7'd1;
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        byte_next = byte_reg;
        x_next    = x_reg;
        row_next  = row_reg;
        left_next = left_reg;
        priority if (start) begin
            busy_next = (count != 4'd0);
            byte_next = data_byte;
            x_next    = x0;
            row_next  = rcnt_reg;
            left_next = count;
        end else if (issue) begin
            busy_next = (left_reg != 4'd1);
            byte_next = byte_shifted;
            x_next    = x_reg + X_W'(1);
            left_next = left_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            left_reg <= 4'd0;
            rbc_reg  <= 7'd0;
            rcnt_reg <= 7'd0;
        end else begin
            busy_reg <= busy_next;
            left_reg <= left_next;
            rbc_reg  <= rbc_next;
            rcnt_reg <= rcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        x_reg    <= x_next;
        row_reg  <= row_next;
    end

    assign can_take  = !busy_reg || (issue && left_reg == 4'd1);
    assign req_valid = busy_reg;
    assign req.x     = x_reg;
    assign req.row   = row_reg;
    assign req.cidx  = cidx;
    assign req.last  = (left_reg == 4'd1);

endmodule

// ----- rtl/masked_indexed_pixel_unpacker_core.sv -----
// Masked indexed pixel unpacker. Words of kind palette write a 256 x 24 color
// store, words of kind mask append a byte to the mask store (wrapping at its
// depth), and pixel words are split into 1, 2, 4 or 8 bit indices, MSB first;
// each pixel inside the image width comes out with its coordinates, index,
// palette color and mask bit. Palette and mask words are stored when taken. A
// pixel word holds the unpacker until each pixel it yields is issued, so the
// block sustains one result per cycle unless the output stalls; the limit is
// the single read port of each store, used once per pixel. Results pass the
// unpacker, stage B and stage C. Stores read as zero until written: the
// palette via one valid bit per entry, the mask store via its write pointer,
// so no clearing pass follows reset. Configuration writes are always taken.
module masked_indexed_pixel_unpacker_core #(
    parameter int MAX_WIDTH        = 64,
    parameter int MAX_HEIGHT       = 64,
    parameter int MASK_STORE_DEPTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mipu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mipu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_kind,
    input  logic [7:0]                        s_entry_index,
    input  logic [7:0]                        s_entry_red,
    input  logic [7:0]                        s_entry_green,
    input  logic [7:0]                        s_entry_blue,
    input  logic [7:0]                        s_data_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [5:0]                        m_pixel_x,
    output logic [5:0]                        m_pixel_y,
    output logic [7:0]                        m_color_index,
    output logic [7:0]                        m_out_red,
    output logic [7:0]                        m_out_green,
    output logic [7:0]                        m_out_blue,
    output logic                              m_visible,
    output logic                              m_last_of_byte
);
    import mipu_pkg::*;

    localparam int MADDR_W = $clog2(MASK_STORE_DEPTH);

    cfg_t cfg_reg;

    logic        accept;
    logic        start;
    logic        can_take;
    logic        req_valid;
    pix_req_t    req;
    logic        issue;

    logic [PALETTE_DEPTH-1:0] pal_valid_reg;
    logic [MADDR_W-1:0]       wp_reg;
    logic                     wrapped_reg;
    logic                     pal_we;
    logic                     mask_we;
    logic [COLOR_W-1:0]       pal_rdata;
    logic [7:0]               mask_rdata;
    logic [MASK_CALC_W-1:0]   mask_addr;
    logic                     mask_ok;

    // stage B: store read in flight
    logic                     b_valid_reg;
    logic                     b_adv;
    logic [5:0]               b_x_reg;
    logic [5:0]               b_y_reg;
    logic [7:0]               b_cidx_reg;
    logic                     b_last_reg;
    logic                     b_pal_ok_reg;
    logic                     b_mask_ok_reg;
    logic [2:0]               b_bit_reg;

    // stage C: output word
    logic                     m_valid_reg;
    logic [5:0]               x_out_reg;
    logic [5:0]               y_out_reg;
    logic [7:0]               cidx_out_reg;
    logic [COLOR_W-1:0]       color_out_reg;
    logic                     vis_out_reg;
    logic                     last_out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.depth_code      <= 2'd3;
            cfg_reg.image_width     <= 7'd32;
            cfg_reg.image_height    <= 7'd32;
            cfg_reg.pixel_row_bytes <= 8'd32;
            cfg_reg.mask_row_bytes  <= 5'd4;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DEPTH_CODE:      cfg_reg.depth_code      <= cfg_wdata[1:0];
                CFG_IMAGE_WIDTH:     cfg_reg.image_width     <= cfg_wdata[6:0];
                CFG_IMAGE_HEIGHT:    cfg_reg.image_height    <= cfg_wdata[6:0];
                CFG_PIXEL_ROW_BYTES: cfg_reg.pixel_row_bytes <= cfg_wdata;
                CFG_MASK_ROW_BYTES:  cfg_reg.mask_row_bytes  <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    assign s_ready = can_take;
    assign accept  = s_valid && s_ready;
    assign pal_we  = accept && (s_kind == KIND_PALETTE);
    assign mask_we = accept && (s_kind == KIND_MASK);
    assign start   = accept && (s_kind == KIND_PIXEL);

    mipu_unpack #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_unpack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .start     (start),
        .data_byte (s_data_byte),
        .issue     (issue),
        .can_take  (can_take),
        .req_valid (req_valid),
        .req       (req)
    );

    assign b_adv = b_valid_reg && (!m_valid_reg || m_ready);
    assign issue = req_valid && (!b_valid_reg || b_adv);

    assign mask_addr = MASK_CALC_W'(req.row) * MASK_CALC_W'(cfg_reg.mask_row_bytes)
                     + MASK_CALC_W'(req.x[X_W-1:3]);
    assign mask_ok   = (32'(mask_addr) < MASK_STORE_DEPTH)
                     && (wrapped_reg || (32'(mask_addr) < 32'(wp_reg)));

    mipu_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette_ram (
        .aclk  (aclk),
        .we    (pal_we),
        .waddr (s_entry_index),
        .wdata ({s_entry_red, s_entry_green, s_entry_blue}),
        .re    (issue),
        .raddr (req.cidx),
        .rdata (pal_rdata)
    );

    mipu_ram #(
        .WIDTH (8),
        .DEPTH (MASK_STORE_DEPTH)
    ) u_mask_ram (
        .aclk  (aclk),
        .we    (mask_we),
        .waddr (wp_reg),
        .wdata (s_data_byte),
        .re    (issue),
        .raddr (MADDR_W'(mask_addr)),
        .rdata (mask_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pal_valid_reg <= '0;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
        end else begin
            if (pal_we) begin
                pal_valid_reg[s_entry_index] <= 1'b1;
            end
            if (mask_we) begin
                if (32'(wp_reg) == MASK_STORE_DEPTH - 1) begin
                    wp_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end else begin
                    wp_reg <= wp_reg + MADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (issue) begin
            b_valid_reg <= 1'b1;
        end else if (b_adv) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            b_x_reg       <= req.x[5:0];
            b_y_reg       <= req.row[5:0];
            b_cidx_reg    <= req.cidx;
            b_last_reg    <= req.last;
            b_pal_ok_reg  <= pal_valid_reg[req.cidx];
            b_mask_ok_reg <= mask_ok;
            b_bit_reg     <= 3'd7 - req.x[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv) begin
            x_out_reg     <= b_x_reg;
            y_out_reg     <= b_y_reg;
            cidx_out_reg  <= b_cidx_reg;
            color_out_reg <= b_pal_ok_reg ? pal_rdata : '0;
            vis_out_reg   <= b_mask_ok_reg && mask_rdata[b_bit_reg];
            last_out_reg  <= b_last_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_x      = x_out_reg;
    assign m_pixel_y      = y_out_reg;
    assign m_color_index  = cidx_out_reg;
    assign m_out_red      = color_out_reg[23:16];
    assign m_out_green    = color_out_reg[15:8];
    assign m_out_blue     = color_out_reg[7:0];
    assign m_visible      = vis_out_reg;
    assign m_last_of_byte = last_out_reg;

endmodule
